// ----- rtl/sbmq_pkg.sv -----
`default_nettype none

package sbmq_pkg;

    localparam int DEF_NUM_SLOTS  = 16;
    localparam int DEF_NUM_QUEUES = 4;

    localparam int DATA_W    = 32;
    localparam int QID_W     = 2;
    localparam int QID_COUNT = 1 << QID_W;

    typedef enum logic {
        ACT_ENQ = 1'b0,
        ACT_DEQ = 1'b1
    } action_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_OVERFLOW  = 2'd1,
        STAT_UNDERFLOW = 2'd2
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } state_t;

endpackage

`default_nettype wire

// ----- rtl/shared_buffer_multi_queue.sv -----
`default_nettype none

// Channel  | Dir | Handshake            | Payload
// ---------+-----+----------------------+---------------------------
// input    | in  | in_valid / in_stall   | action, queue_id, value
// output   | out | out_valid / out_stall | read_value, status
//
// In each transaction the accept cycle reads the link memory and
// reads or writes the data memory, the next cycle writes at most one link entry
// and loads the result register; the link memory is read first and written after.
// Reset clears the queue pointers and free head; the link memory needs no
// clearing pass, a fill count stands in for the initial free chain.
// Input stalls in the execute state and while a held result is stalled.

module shared_buffer_multi_queue #(
    parameter int NUM_SLOTS  = sbmq_pkg::DEF_NUM_SLOTS,
    parameter int NUM_QUEUES = sbmq_pkg::DEF_NUM_QUEUES
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic                                action,
    input  wire logic [sbmq_pkg::QID_W-1:0]          queue_id,
    input  wire logic signed [sbmq_pkg::DATA_W-1:0]  value,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic signed [sbmq_pkg::DATA_W-1:0]       read_value,
    output logic [1:0]                               status
);
    import sbmq_pkg::*;

    localparam int ADDR_W = $clog2(NUM_SLOTS);
    localparam int SLOT_W = $clog2(NUM_SLOTS + 1);
    localparam logic [SLOT_W-1:0] NONE = SLOT_W'(NUM_SLOTS);

    state_t state_reg;
    state_t state_next;

    logic [SLOT_W-1:0] head_reg [QID_COUNT];
    logic [SLOT_W-1:0] tail_reg [QID_COUNT];
    logic [SLOT_W-1:0] free_head_reg;

    action_t           act_reg;
    logic [QID_W-1:0]  qid_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic              ok_reg;

    logic                     out_valid_reg;
    logic signed [DATA_W-1:0] read_value_reg;
    status_t                  status_reg;

    logic              accept;
    logic              exec;
    logic              q_ok;
    logic [SLOT_W-1:0] slot_a;
    logic              ok_a;
    logic              is_enq_a;
    logic              is_enq_b;
    logic [SLOT_W-1:0] head_b;
    logic [SLOT_W-1:0] tail_b;

    logic                     link_rd_en;
    logic                     link_wr_en;
    logic [ADDR_W-1:0]        link_wr_addr;
    logic [SLOT_W-1:0]        link_wr_data;
    logic                     link_alloc;
    logic [SLOT_W-1:0]        link_q;
    logic                     data_rd_en;
    logic                     data_wr_en;
    logic signed [DATA_W-1:0] data_q;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall = 1'b1;
        accept   = 1'b0;
        exec     = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall = out_valid_reg && out_stall;
                accept   = in_valid && !(out_valid_reg && out_stall);
            end
            S_EXEC:
            begin
                exec = 1'b1;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase

        // Accept cycle: pick the slot and issue the memory reads and the data write.
        is_enq_a   = (action == ACT_ENQ);
        q_ok       = (32'(queue_id) < NUM_QUEUES);
        slot_a     = is_enq_a ? free_head_reg : head_reg[queue_id];
        ok_a       = q_ok && (slot_a < NONE);
        link_rd_en = accept && ok_a;
        data_rd_en = accept && ok_a && !is_enq_a;
        data_wr_en = accept && ok_a && is_enq_a;

        // Execute cycle: relink. Enqueue chains the old tail, dequeue pushes on the free list.
        is_enq_b   = (act_reg == ACT_ENQ);
        head_b     = head_reg[qid_reg];
        tail_b     = tail_reg[qid_reg];
        link_alloc = exec && ok_reg && is_enq_b;
        link_wr_en = exec && ok_reg && (is_enq_b ? (head_b < NONE) : 1'b1);
        link_wr_addr = is_enq_b ? tail_b[ADDR_W-1:0] : slot_reg[ADDR_W-1:0];
        link_wr_data = is_enq_b ? slot_reg : free_head_reg;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg  <= action_t'(action);
            qid_reg  <= queue_id;
            slot_reg <= slot_a;
            ok_reg   <= ok_a;
        end
        if (exec)
        begin
            if (is_enq_b)
            begin
                read_value_reg <= '0;
                status_reg     <= ok_reg ? STAT_OK : STAT_OVERFLOW;
            end
            else
            begin
                read_value_reg <= ok_reg ? data_q : '1;
                status_reg     <= ok_reg ? STAT_OK : STAT_UNDERFLOW;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            free_head_reg <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < QID_COUNT; i++)
            begin
                head_reg[i] <= NONE;
                tail_reg[i] <= NONE;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (exec)
            begin
                out_valid_reg <= 1'b1;
                if (ok_reg)
                begin
                    if (is_enq_b)
                    begin
                        free_head_reg <= link_q;
                        if (!(head_b < NONE))
                        begin
                            head_reg[qid_reg] <= slot_reg;
                        end
                        tail_reg[qid_reg] <= slot_reg;
                    end
                    else
                    begin
                        // The tail slot ends the chain; its link may be stale.
                        head_reg[qid_reg] <= (slot_reg == tail_b) ? NONE : link_q;
                        free_head_reg     <= slot_reg;
                    end
                end
            end
        end
    end

    sbmq_link_ram #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_link_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (link_rd_en),
        .rd_addr (slot_a[ADDR_W-1:0]),
        .wr_en   (link_wr_en),
        .wr_addr (link_wr_addr),
        .wr_data (link_wr_data),
        .alloc   (link_alloc),
        .rd_link (link_q)
    );

    sbmq_data_ram #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_data_ram (
        .clk     (clk),
        .wr_en   (data_wr_en),
        .wr_addr (slot_a[ADDR_W-1:0]),
        .wr_data (value),
        .rd_en   (data_rd_en),
        .rd_addr (slot_a[ADDR_W-1:0]),
        .rd_data (data_q)
    );

    assign out_valid  = out_valid_reg;
    assign read_value = read_value_reg;
    assign status     = status_reg;

endmodule

`default_nettype wire

// ----- rtl/sbmq_data_ram.sv -----
`default_nettype none

module sbmq_data_ram #(
    parameter int NUM_SLOTS = sbmq_pkg::DEF_NUM_SLOTS
) (
    input  wire logic                                clk,
    input  wire logic                                wr_en,
    input  wire logic [$clog2(NUM_SLOTS)-1:0]        wr_addr,
    input  wire logic signed [sbmq_pkg::DATA_W-1:0]  wr_data,
    input  wire logic                                rd_en,
    input  wire logic [$clog2(NUM_SLOTS)-1:0]        rd_addr,
    output logic signed [sbmq_pkg::DATA_W-1:0]       rd_data
);
    import sbmq_pkg::*;

    logic signed [DATA_W-1:0] data_mem [NUM_SLOTS];
    logic signed [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            data_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= data_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- rtl/sbmq_link_ram.sv -----
`default_nettype none

module sbmq_link_ram #(
    parameter int NUM_SLOTS = sbmq_pkg::DEF_NUM_SLOTS
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 rd_en,
    input  wire logic [$clog2(NUM_SLOTS)-1:0]         rd_addr,
    input  wire logic                                 wr_en,
    input  wire logic [$clog2(NUM_SLOTS)-1:0]         wr_addr,
    input  wire logic [$clog2(NUM_SLOTS+1)-1:0]       wr_data,
    input  wire logic                                 alloc,
    output logic [$clog2(NUM_SLOTS+1)-1:0]            rd_link
);
    import sbmq_pkg::*;

    localparam int SLOT_W = $clog2(NUM_SLOTS + 1);

    logic [SLOT_W-1:0] link_mem [NUM_SLOTS];
    logic [SLOT_W-1:0] link_q_reg;
    logic [SLOT_W-1:0] fresh_link_reg;
    // Slots at or above the fill count were never written; their link is index plus one.
    logic [SLOT_W-1:0] fresh_reg;
    logic [SLOT_W-1:0] fresh_next;
    logic              hit_reg;
    logic              hit_next;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            link_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            link_q_reg     <= link_mem[rd_addr];
            fresh_link_reg <= fresh_reg + 1'b1;
        end
    end

    always_comb
    begin
        hit_next   = hit_reg;
        fresh_next = fresh_reg;
        if (rd_en)
        begin
            hit_next = (SLOT_W'(rd_addr) == fresh_reg);
        end
        // Advance the fill count when an untouched slot leaves the free list.
        if (alloc && hit_reg)
        begin
            fresh_next = fresh_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg   <= 1'b0;
            fresh_reg <= '0;
        end
        else
        begin
            hit_reg   <= hit_next;
            fresh_reg <= fresh_next;
        end
    end

    assign rd_link = hit_reg ? fresh_link_reg : link_q_reg;

endmodule

`default_nettype wire

// ----- verif/shared_buffer_multi_queue_tb.sv -----
`timescale 1ns / 1ps

module shared_buffer_multi_queue_tb;
    import sbmq_pkg::*;

    localparam int SLOTS        = DEF_NUM_SLOTS;
    localparam int QUEUES       = DEF_NUM_QUEUES;
    localparam int IDX_W        = $clog2(SLOTS + 1);
    localparam int ADDR_BITS    = $clog2(SLOTS);
    localparam logic [IDX_W-1:0] NO_SLOT = IDX_W'(SLOTS);
    localparam int RANDOM_ITEMS = 525;
    localparam int STUCK_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 8;

    // Slot pool predictor plus the list of replies still owed by the block.
    class slot_pool_scoreboard;
        logic [IDX_W-1:0]  head_slot [QUEUES];
        logic [IDX_W-1:0]  tail_slot [QUEUES];
        logic [IDX_W-1:0]  next_slot [SLOTS];
        logic [DATA_W-1:0] slot_word [SLOTS];
        logic [IDX_W-1:0]  free_slot;
        logic [DATA_W-1:0] owed_word [$];
        status_t           owed_status [$];
        int errors;
        int enq_count;
        int deq_count;
        int overflow_count;
        int underflow_count;

        function new();
            for (int q = 0; q < QUEUES; q++)
            begin
                head_slot[q] = NO_SLOT;
                tail_slot[q] = NO_SLOT;
            end
            // last link comes out as NO_SLOT
            for (int s = 0; s < SLOTS; s++)
            begin
                next_slot[s] = IDX_W'(s + 1);
                slot_word[s] = '0;
            end
            free_slot       = '0;
            errors          = 0;
            enq_count       = 0;
            deq_count       = 0;
            overflow_count  = 0;
            underflow_count = 0;
        endfunction

        function void note_request(action_t act, logic [QID_W-1:0] q,
                                   logic [DATA_W-1:0] word);
            logic [IDX_W-1:0]  s;
            logic [IDX_W-1:0]  t;
            logic [DATA_W-1:0] rd;
            status_t           st;
            rd = '0;
            st = STAT_OK;
            if (act == ACT_ENQ)
            begin
                if (q >= QUEUES || free_slot >= SLOTS)
                begin
                    st = STAT_OVERFLOW;
                    overflow_count++;
                end
                else
                begin
                    s         = free_slot;
                    free_slot = next_slot[s[ADDR_BITS-1:0]];
                    t         = tail_slot[q];
                    // an empty queue keeps a stale tail, so relink only when head is live
                    if (head_slot[q] >= SLOTS)
                        head_slot[q] = s;
                    else if (t < SLOTS)
                        next_slot[t[ADDR_BITS-1:0]] = s;
                    next_slot[s[ADDR_BITS-1:0]] = NO_SLOT;
                    tail_slot[q] = s;
                    slot_word[s[ADDR_BITS-1:0]] = word;
                    enq_count++;
                end
            end
            else
            begin
                if (q >= QUEUES || head_slot[q] >= SLOTS)
                begin
                    rd = '1;
                    st = STAT_UNDERFLOW;
                    underflow_count++;
                end
                else
                begin
                    s            = head_slot[q];
                    head_slot[q] = next_slot[s[ADDR_BITS-1:0]];
                    next_slot[s[ADDR_BITS-1:0]] = free_slot;
                    free_slot    = s;
                    rd           = slot_word[s[ADDR_BITS-1:0]];
                    deq_count++;
                end
            end
            owed_word.push_back(rd);
            owed_status.push_back(st);
        endfunction

        function void check_result(logic [DATA_W-1:0] rd, logic [1:0] st);
            logic [DATA_W-1:0] want_rd;
            status_t           want_st;
            if (owed_word.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result: read_value %h status %0d", $time, rd, st);
                return;
            end
            want_rd = owed_word.pop_front();
            want_st = owed_status.pop_front();
            if (rd !== want_rd)
            begin
                errors++;
                $display("%0t: read_value mismatch: expected %h actual %h",
                         $time, want_rd, rd);
            end
            if (st !== want_st)
            begin
                errors++;
                $display("%0t: status mismatch: expected %0d actual %0d",
                         $time, want_st, st);
            end
        endfunction
    endclass

    logic                     clk        = 1'b0;
    logic                     rst_n      = 1'b0;
    logic                     in_valid   = 1'b0;
    logic                     action     = ACT_ENQ;
    logic [QID_W-1:0]         queue_id   = '0;
    logic signed [DATA_W-1:0] value      = '0;
    logic                     out_stall  = 1'b0;
    logic                     in_stall;
    logic                     out_valid;
    logic signed [DATA_W-1:0] read_value;
    logic [1:0]               status;

    int send_idle_pct  = 7;
    int recv_stall_pct = 46;
    int stuck_cycles   = 0;

    slot_pool_scoreboard pool_model = new();

    shared_buffer_multi_queue uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .action     (action),
        .queue_id   (queue_id),
        .value      (value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .read_value (read_value),
        .status     (status)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
        out_stall <= ($urandom_range(99) < recv_stall_pct);

    // Transaction monitor and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                pool_model.note_request(action_t'(action), queue_id, value);
            if (out_valid && !out_stall)
                pool_model.check_result(read_value, status);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                stuck_cycles <= 0;
            else
                stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles >= STUCK_LIMIT)
            begin
                $display("%0t: no transaction for %0d cycles", $time, STUCK_LIMIT);
                $display("shared_buffer_multi_queue verification failed");
                $finish;
            end
        end
    end

    // Hold valid across back-to-back items; drop it only for an idle gap.
    task automatic send_item(input action_t act, input logic [QID_W-1:0] q,
                             input logic [DATA_W-1:0] word);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        action   <= act;
        queue_id <= q;
        value    <= word;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    initial
    begin
        int enq_bias;
        enq_bias = 50;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(ACT_DEQ, 2'd0, 32'h0);
        send_item(ACT_ENQ, 2'd0, 32'h7fff_ffff);
        send_item(ACT_ENQ, 2'd3, 32'h8000_0000);
        // empty queue 0, then refill it over its stale tail
        send_item(ACT_DEQ, 2'd0, 32'h1234_5678);
        send_item(ACT_ENQ, 2'd0, 32'hffff_ffff);
        send_item(ACT_ENQ, 2'd1, 32'h0);
        for (int i = 0; i < SLOTS - 3; i++)
            send_item(ACT_ENQ, QID_W'(i), (i % 2) ? 32'haaaa_aaaa : 32'h5555_5555);
        send_item(ACT_ENQ, 2'd2, 32'hdead_beef);
        for (int q = 0; q < QUEUES; q++)
            send_item(ACT_DEQ, QID_W'(q), $urandom());

        for (int p = 0; p < 3; p++)
        begin
            send_idle_pct  = (p == 0) ? 7 : (p == 1) ? 46 : 0;
            recv_stall_pct = (p == 0) ? 46 : (p == 1) ? 7 : 0;
            for (int i = 0; i < RANDOM_ITEMS / 3; i++)
            begin
                // swing occupancy between full and empty in bursts
                if (i % 32 == 0)
                    enq_bias = ($urandom_range(2) == 0) ? 15 :
                               ($urandom_range(1) == 0) ? 50 : 85;
                send_item(($urandom_range(99) < enq_bias) ? ACT_ENQ : ACT_DEQ,
                          QID_W'($urandom_range(QUEUES - 1)), $urandom());
            end
        end
        in_valid <= 1'b0;

        while (pool_model.owed_word.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d stored and %0d returned words, %0d full-pool drops,",
                 pool_model.enq_count, pool_model.deq_count, pool_model.overflow_count);
        $display("%0d empty reads under three sender/receiver pacing mixes; %0d errors.",
                 pool_model.underflow_count, pool_model.errors);
        if (pool_model.errors == 0)
            $display("shared_buffer_multi_queue verification clean");
        else
            $display("shared_buffer_multi_queue verification failed");
        $finish;
    end

endmodule
